/* hdl/mbfe_pkg.sv */
// ============================================================================
// mbfe_pkg
// Shared codes and reset values of the Modbus RTU frame engine.
// ============================================================================
package mbfe_pkg;

    // Defaults and reset values
    localparam int DEF_BUFFER_BYTES = 32;
    localparam logic [7:0]  FIRST_BYTE_TIMEOUT_RST = 8'd100;
    localparam logic [7:0]  CHAR_GAP_TIMEOUT_RST   = 8'd30;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam int MIN_FRAME_BYTES = 4;
    localparam int CRC_BYTES       = 2;

    // Configuration register indexes
    localparam logic REG_FIRST_BYTE_TIMEOUT = 1'b0;
    localparam logic REG_CHAR_GAP_TIMEOUT   = 1'b1;

    // Input opcodes
    localparam logic [2:0] OP_ARM     = 3'd0;
    localparam logic [2:0] OP_RX_BYTE = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_TX_BYTE = 3'd3;
    localparam logic [2:0] OP_TX_END  = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_RX_BYTE = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_TX_BYTE = 2'd2;

    // Receive status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERRUN   = 3'd1;
    localparam logic [2:0] ST_CRC_ERROR = 3'd2;
    localparam logic [2:0] ST_TIMEOUT   = 3'd3;
    localparam logic [2:0] ST_FRAME_ERR = 3'd4;

endpackage

/* hdl/mbfe_crc16.sv */
// ============================================================================
// mbfe_crc16
// Folds one byte into a Modbus CRC-16 (reflected, polynomial 0xA001).
// ============================================================================
module mbfe_crc16 (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import mbfe_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

/* hdl/mbfe_frame_ram.sv */
// ============================================================================
// mbfe_frame_ram
// Frame byte store: one write port, one read port, registered read data.
// ============================================================================
module mbfe_frame_ram #(
    parameter int DEPTH = mbfe_pkg::DEF_BUFFER_BYTES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/modbus_rtu_frame_engine.sv */
// ============================================================================
// modbus_rtu_frame_engine
// Modbus RTU receive deframer and transmit framer with CRC-16.
// ============================================================================
//
// Usage:
//   Input channel (in_valid/in_ready, opcode, data_byte) carries one command
//   word: arm receive, received byte, timer tick, transmit byte, transmit end.
//   Output channel (out_valid/out_ready, kind, out_byte, status,
//   payload_length, last) carries result words; last marks the final word of
//   a run. cfg_we/cfg_index/cfg_wdata write the two timeout registers.
//   Throughput: a word that causes no result leaves the engine idle. A good
//   frame end or a transmit end walks the frame RAM at one word per cycle
//   while the receiver is ready, then closes the walk and loads the trailer
//   words. in_ready stays low until the last word of a run is loaded into
//   the output register. A status-only result (overrun, timeout, frame or
//   CRC error) is loaded from S_FINAL once the output register is free.
//   Reset: receive disarmed, byte count zero, CRC 0xFFFF, timeouts 100/30.
//   The frame RAM is not cleared; only bytes written in the current frame
//   are ever read back.
//   Receiver stall: the output register holds its word while out_ready is
//   low and the walk pauses; nothing is dropped.
//
module modbus_rtu_frame_engine #(
    parameter int BUFFER_BYTES = mbfe_pkg::DEF_BUFFER_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    // Command words
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [7:0] data_byte,
    // Result words
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [2:0] status,
    output logic [4:0] payload_length,
    output logic       last
);
    import mbfe_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_CRC_LO,
        S_FINAL
    } state_t;

    // Control and frame state
    state_t        state_reg,  state_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [15:0]   crc_reg,    crc_next;
    logic [7:0]    timer_reg,  timer_next;
    logic          armed_reg,  armed_next;
    logic [7:0]    fbt_reg,    fbt_next;
    logic [7:0]    cgt_reg,    cgt_next;

    // Walk over the frame RAM
    logic [CW-1:0] walk_idx_reg, walk_idx_next;
    logic [CW-1:0] walk_len_reg, walk_len_next;
    logic          walk_tx_reg,  walk_tx_next;
    logic          rd_pend_reg,  rd_pend_next;

    // Trailer words
    logic [7:0]    crc_lo_reg,     crc_lo_next;
    logic [1:0]    fin_kind_reg,   fin_kind_next;
    logic [7:0]    fin_byte_reg,   fin_byte_next;
    logic [2:0]    fin_status_reg, fin_status_next;
    logic [4:0]    fin_len_reg,    fin_len_next;

    // Output register
    logic          out_valid_reg,  out_valid_next;
    logic [1:0]    kind_reg,       kind_next;
    logic [7:0]    out_byte_reg,   out_byte_next;
    logic [2:0]    status_reg,     status_next;
    logic [4:0]    plen_reg,       plen_next;
    logic          last_reg,       last_next;

    // RAM and CRC unit
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [15:0]   crc_fold;

    logic          accept;
    logic          out_free;
    logic [7:0]    timer_dec;
    logic [LW-1:0] plen_wide;
    logic [CW:0]   tx_total;
    logic          issue;
    logic          load_walk;

    mbfe_crc16 u_crc (
        .crc_in  (crc_reg),
        .data_in (data_byte),
        .crc_out (crc_fold)
    );

    mbfe_frame_ram #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign accept         = in_valid && in_ready;
    assign out_free       = !out_valid_reg || out_ready;
    assign timer_dec      = (timer_reg != 8'd0) ? (timer_reg - 8'd1) : 8'd0;
    assign plen_wide      = LW'(count_reg) - LW'(CRC_BYTES);
    assign tx_total       = (CW+1)'(count_reg) + (CW+1)'(CRC_BYTES);
    assign ram_waddr      = count_reg[AW-1:0];
    assign ram_raddr      = walk_idx_reg[AW-1:0];

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign out_byte       = out_byte_reg;
    assign status         = status_reg;
    assign payload_length = plen_reg;
    assign last           = last_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        crc_next        = crc_reg;
        timer_next      = timer_reg;
        armed_next      = armed_reg;
        fbt_next        = fbt_reg;
        cgt_next        = cgt_reg;
        walk_idx_next   = walk_idx_reg;
        walk_len_next   = walk_len_reg;
        walk_tx_next    = walk_tx_reg;
        rd_pend_next    = rd_pend_reg;
        crc_lo_next     = crc_lo_reg;
        fin_kind_next   = fin_kind_reg;
        fin_byte_next   = fin_byte_reg;
        fin_status_next = fin_status_reg;
        fin_len_next    = fin_len_reg;
        out_valid_next  = out_valid_reg;
        kind_next       = kind_reg;
        out_byte_next   = out_byte_reg;
        status_next     = status_reg;
        plen_next       = plen_reg;
        last_next       = last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        issue           = 1'b0;
        load_walk       = 1'b0;

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIRST_BYTE_TIMEOUT: fbt_next = cfg_wdata;
                REG_CHAR_GAP_TIMEOUT:   cgt_next = cfg_wdata;
                default:                fbt_next = fbt_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_ARM:
                        begin
                            count_next = '0;
                            crc_next   = CRC_INIT;
                            timer_next = fbt_reg;
                            armed_next = 1'b1;
                        end
                        OP_RX_BYTE:
                        begin
                            if (armed_reg)
                            begin
                                ram_we = 1'b1;
                                if (count_reg == CW'(BUFFER_BYTES - 1))
                                begin
                                    // Store full: overrun ends the receive
                                    armed_next      = 1'b0;
                                    timer_next      = 8'd0;
                                    count_next      = '0;
                                    crc_next        = CRC_INIT;
                                    fin_kind_next   = KIND_STATUS;
                                    fin_byte_next   = 8'd0;
                                    fin_status_next = ST_OVERRUN;
                                    fin_len_next    = 5'd0;
                                    state_next      = S_FINAL;
                                end
                                else
                                begin
                                    timer_next = cgt_reg;
                                    count_next = count_reg + CW'(1);
                                    crc_next   = crc_fold;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            if (armed_reg)
                            begin
                                timer_next = timer_dec;
                                if (timer_dec == 8'd0)
                                begin
                                    armed_next      = 1'b0;
                                    count_next      = '0;
                                    crc_next        = CRC_INIT;
                                    fin_kind_next   = KIND_STATUS;
                                    fin_byte_next   = 8'd0;
                                    fin_len_next    = 5'd0;
                                    state_next      = S_FINAL;
                                    if (count_reg == '0)
                                    begin
                                        fin_status_next = ST_TIMEOUT;
                                    end
                                    else if (count_reg < CW'(MIN_FRAME_BYTES))
                                    begin
                                        fin_status_next = ST_FRAME_ERR;
                                    end
                                    else if (crc_reg != 16'd0)
                                    begin
                                        fin_status_next = ST_CRC_ERROR;
                                    end
                                    else
                                    begin
                                        // Good frame: stream payload, then status
                                        fin_status_next = ST_OK;
                                        fin_len_next    = plen_wide[4:0];
                                        walk_len_next   = count_reg - CW'(CRC_BYTES);
                                        walk_idx_next   = '0;
                                        walk_tx_next    = 1'b0;
                                        state_next      = S_WALK;
                                    end
                                end
                            end
                        end
                        OP_TX_BYTE:
                        begin
                            if (!armed_reg && (count_reg < CW'(BUFFER_BYTES)))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                crc_next   = crc_fold;
                            end
                        end
                        OP_TX_END:
                        begin
                            if (!armed_reg)
                            begin
                                count_next = '0;
                                crc_next   = CRC_INIT;
                                if (tx_total < (CW+1)'(BUFFER_BYTES))
                                begin
                                    crc_lo_next     = crc_reg[7:0];
                                    fin_kind_next   = KIND_TX_BYTE;
                                    fin_byte_next   = crc_reg[15:8];
                                    fin_status_next = ST_OK;
                                    fin_len_next    = 5'd0;
                                    walk_len_next   = count_reg;
                                    walk_idx_next   = '0;
                                    walk_tx_next    = 1'b1;
                                    state_next      = S_WALK;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                load_walk = rd_pend_reg && out_free;
                issue     = (walk_idx_reg < walk_len_reg) && (!rd_pend_reg || load_walk);
                if (load_walk)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = walk_tx_reg ? KIND_TX_BYTE : KIND_RX_BYTE;
                    out_byte_next  = ram_rdata;
                    status_next    = ST_OK;
                    plen_next      = 5'd0;
                    last_next      = 1'b0;
                end
                if (issue)
                begin
                    ram_re        = 1'b1;
                    walk_idx_next = walk_idx_reg + CW'(1);
                end
                rd_pend_next = issue || (rd_pend_reg && !load_walk);
                if ((walk_idx_reg == walk_len_reg) && !rd_pend_reg)
                begin
                    state_next = walk_tx_reg ? S_CRC_LO : S_FINAL;
                end
            end
            S_CRC_LO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_TX_BYTE;
                    out_byte_next  = crc_lo_reg;
                    status_next    = ST_OK;
                    plen_next      = 5'd0;
                    last_next      = 1'b0;
                    state_next     = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = fin_kind_reg;
                    out_byte_next  = fin_byte_reg;
                    status_next    = fin_status_reg;
                    plen_next      = fin_len_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            crc_reg        <= CRC_INIT;
            timer_reg      <= 8'd0;
            armed_reg      <= 1'b0;
            fbt_reg        <= FIRST_BYTE_TIMEOUT_RST;
            cgt_reg        <= CHAR_GAP_TIMEOUT_RST;
            walk_idx_reg   <= '0;
            walk_len_reg   <= '0;
            walk_tx_reg    <= 1'b0;
            rd_pend_reg    <= 1'b0;
            crc_lo_reg     <= 8'd0;
            fin_kind_reg   <= KIND_STATUS;
            fin_byte_reg   <= 8'd0;
            fin_status_reg <= ST_OK;
            fin_len_reg    <= 5'd0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_RX_BYTE;
            out_byte_reg   <= 8'd0;
            status_reg     <= ST_OK;
            plen_reg       <= 5'd0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            timer_reg      <= timer_next;
            armed_reg      <= armed_next;
            fbt_reg        <= fbt_next;
            cgt_reg        <= cgt_next;
            walk_idx_reg   <= walk_idx_next;
            walk_len_reg   <= walk_len_next;
            walk_tx_reg    <= walk_tx_next;
            rd_pend_reg    <= rd_pend_next;
            crc_lo_reg     <= crc_lo_next;
            fin_kind_reg   <= fin_kind_next;
            fin_byte_reg   <= fin_byte_next;
            fin_status_reg <= fin_status_next;
            fin_len_reg    <= fin_len_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            out_byte_reg   <= out_byte_next;
            status_reg     <= status_next;
            plen_reg       <= plen_next;
            last_reg       <= last_next;
        end
    end

    // RAM writes and walk reads never share a cycle
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("frame RAM written outside idle");

    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_WALK))
        else $error("read pending outside walk");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (walk_idx_reg <= walk_len_reg))
        else $error("walk index past frame length");

    a_armed_room: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> (count_reg < CW'(BUFFER_BYTES)))
        else $error("armed receive with full store");

endmodule

/* test/modbus_rtu_frame_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// modbus_rtu_frame_checker
// Watches the command, result and register ports of the frame engine, keeps
// its own copy of the receive/transmit state, predicts every result word and
// compares each accepted one, field by field, with the oldest prediction.
// ============================================================================
module modbus_rtu_frame_checker #(
    parameter int BUFFER_BYTES = mbfe_pkg::DEF_BUFFER_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] kind,
    input  logic [7:0] out_byte,
    input  logic [2:0] status,
    input  logic [4:0] payload_length,
    input  logic       last,
    output int         fail_count,
    output int         pending,
    output int         checked_count
);
    import mbfe_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] status;
        logic [4:0] length;
        logic       last;
    } result_word_t;

    result_word_t expected_words [$];

    // Shadow of the engine state
    logic [7:0]  frame_mem [BUFFER_BYTES];
    int unsigned fill;
    logic [15:0] crc_run;
    logic [7:0]  timer;
    logic        armed;
    logic [7:0]  first_to;
    logic [7:0]  gap_to;

    function automatic logic [15:0] crc_fold_byte(input logic [15:0] acc,
                                                  input logic [7:0] b);
        logic [15:0] r;
        int k;
        r = acc ^ {8'h00, b};
        for (k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic bit field_differs(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        return want != got;
    endfunction

    task automatic push_word(input logic [1:0] k, input logic [7:0] d,
                             input logic [2:0] s, input logic [4:0] n, input logic l);
        result_word_t w;
        w.kind   = k;
        w.data   = d;
        w.status = s;
        w.length = n;
        w.last   = l;
        expected_words.push_back(w);
    endtask

    // Drop the receive and return to an empty frame
    task automatic drop_receive();
        armed   = 1'b0;
        timer   = 8'd0;
        fill    = 0;
        crc_run = CRC_INIT;
    endtask

    task automatic close_frame();
        int unsigned plen;
        int unsigned i;
        if (fill == 0)
            push_word(KIND_STATUS, 8'd0, ST_TIMEOUT, 5'd0, 1'b1);
        else if (fill < MIN_FRAME_BYTES)
            push_word(KIND_STATUS, 8'd0, ST_FRAME_ERR, 5'd0, 1'b1);
        else if (crc_run != 16'd0)
            push_word(KIND_STATUS, 8'd0, ST_CRC_ERROR, 5'd0, 1'b1);
        else begin
            plen = fill - CRC_BYTES;
            for (i = 0; i < plen && i < BUFFER_BYTES; i++)
                push_word(KIND_RX_BYTE, frame_mem[i], ST_OK, 5'd0, 1'b0);
            push_word(KIND_STATUS, 8'd0, ST_OK, 5'(plen), 1'b1);
        end
        drop_receive();
    endtask

    task automatic predict_command(input logic [2:0] op, input logic [7:0] b);
        logic [15:0] c;
        int unsigned i;
        case (op)
            OP_ARM: begin
                fill    = 0;
                crc_run = CRC_INIT;
                timer   = first_to;
                armed   = 1'b1;
            end
            OP_RX_BYTE: begin
                if (armed) begin
                    timer = gap_to;
                    if (fill < BUFFER_BYTES)
                        frame_mem[fill] = b;
                    fill++;
                    crc_run = crc_fold_byte(crc_run, b);
                    if (fill >= BUFFER_BYTES) begin
                        push_word(KIND_STATUS, 8'd0, ST_OVERRUN, 5'd0, 1'b1);
                        drop_receive();
                    end
                end
            end
            OP_TICK: begin
                if (armed) begin
                    if (timer != 8'd0)
                        timer--;
                    if (timer == 8'd0)
                        close_frame();
                end
            end
            OP_TX_BYTE: begin
                if (!armed && fill < BUFFER_BYTES) begin
                    frame_mem[fill] = b;
                    fill++;
                    crc_run = crc_fold_byte(crc_run, b);
                end
            end
            OP_TX_END: begin
                if (!armed) begin
                    if (fill + CRC_BYTES < BUFFER_BYTES) begin
                        c = crc_run;
                        for (i = 0; i < fill; i++)
                            push_word(KIND_TX_BYTE, frame_mem[i], ST_OK, 5'd0, 1'b0);
                        push_word(KIND_TX_BYTE, c[7:0], ST_OK, 5'd0, 1'b0);
                        push_word(KIND_TX_BYTE, c[15:8], ST_OK, 5'd0, 1'b1);
                    end
                    fill    = 0;
                    crc_run = CRC_INIT;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_word_t want;
        bit bad;
        if (!rst_n) begin
            expected_words.delete();
            drop_receive();
            first_to      = FIRST_BYTE_TIMEOUT_RST;
            gap_to        = CHAR_GAP_TIMEOUT_RST;
            fail_count    = 0;
            checked_count = 0;
            pending      <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_FIRST_BYTE_TIMEOUT)
                    first_to = cfg_wdata;
                else
                    gap_to = cfg_wdata;
            end
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected: kind %0d byte %0h status %0d length %0d last %0d",
                             $time, kind, out_byte, status, payload_length, last);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    bad = field_differs("kind", want.kind, kind)
                        | field_differs("out_byte", want.data, out_byte)
                        | field_differs("status", want.status, status)
                        | field_differs("payload_length", want.length, payload_length)
                        | field_differs("last", want.last, last);
                    if (bad)
                        fail_count++;
                    checked_count++;
                end
            end
            if (in_valid && in_ready)
                predict_command(opcode, data_byte);
            pending <= expected_words.size();
        end
    end

endmodule

/* test/tb_modbus_rtu_frame_engine.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_modbus_rtu_frame_engine
// Drives command words into the Modbus RTU frame engine: a short directed
// pass over timeout, frame, CRC and overrun endings, transmit framing and
// ignored words, then phases of random frames under changing timeouts.
// A checker beside the engine predicts and compares every result word.
// ============================================================================
module tb_modbus_rtu_frame_engine;
    import mbfe_pkg::*;

    localparam int ITEM_TARGET    = 330;
    localparam int SETTLE_CYCLES  = 64;    // longer than a full 31-word result run
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
    localparam int BUFFER_BYTES_TB = DEF_BUFFER_BYTES;
    // Opcodes the engine does not decode
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic [4:0] payload_length;
    logic       last;

    int fail_count;
    int pending;
    int checked_count;

    int items_sent  = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    int phase_count = 0;
    bit quiet       = 1'b0;          // no idling on either side while set

    // Timeouts as last written, used to size tick runs
    logic [7:0] first_cfg = FIRST_BYTE_TIMEOUT_RST;
    logic [7:0] gap_cfg   = CHAR_GAP_TIMEOUT_RST;

    modbus_rtu_frame_engine DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .out_byte       (out_byte),
        .status         (status),
        .payload_length (payload_length),
        .last           (last)
    );

    modbus_rtu_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .out_byte       (out_byte),
        .status         (status),
        .payload_length (payload_length),
        .last           (last),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked_count  (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    // CRC-16 over the bytes of a frame, to close well-formed frames
    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        int k;
        r = acc ^ {8'h00, b};
        for (k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // Offer one command word and hold it until the engine takes it. Valid is
    // left high on return so that a back-to-back word follows without a gap.
    task automatic send_word(input logic [2:0] op, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(OP_TICK, rnd_byte());
    endtask

    task automatic send_tx(input int n);
        repeat (n) send_word(OP_TX_BYTE, rnd_byte());
        send_word(OP_TX_END, rnd_byte());
    endtask

    // Arm, feed nbytes (last two the CRC when good), then tick the gap
    // timer down so the frame ends. Ticks placed before the first byte and
    // between bytes stay short of the timeout, so they only run it down.
    task automatic send_rx_frame(input int nbytes, input bit good);
        logic [7:0] body [$];
        logic [15:0] acc;
        int left;
        int burst;
        int k;
        acc = CRC_INIT;
        for (k = 0; k < nbytes; k++)
        begin
            if (good && k >= nbytes - CRC_BYTES)
                body.push_back((k == nbytes - CRC_BYTES) ? acc[7:0] : acc[15:8]);
            else
            begin
                body.push_back(rnd_byte());
                acc = crc16_next(acc, body[k]);
            end
        end
        send_word(OP_ARM, rnd_byte());
        left = first_cfg;
        if (left > 1 && $urandom_range(1) == 0)
        begin
            burst = $urandom_range((left > 4) ? 3 : left - 1, 1);
            send_ticks(burst);
            left -= burst;
        end
        for (k = 0; k < nbytes; k++)
        begin
            send_word(OP_RX_BYTE, body[k]);
            left = gap_cfg;
            if (k < BUFFER_BYTES_TB - 1 && left > 1 && $urandom_range(3) == 0)
            begin
                burst = $urandom_range((left > 4) ? 3 : left - 1, 1);
                send_ticks(burst);
                left -= burst;
            end
        end
        // An overrun has already closed the frame; skip the run-down
        if (nbytes < BUFFER_BYTES_TB)
            send_ticks((left > 0) ? left : 1);
    endtask

    // Lower valid, let every predicted word arrive, then let the engine
    // settle before anything touches the registers
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic settle_and_configure(input logic [7:0] first, input logic [7:0] gap);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FIRST_BYTE_TIMEOUT;
        cfg_wdata <= first;
        @(posedge clk);
        cfg_index <= REG_CHAR_GAP_TIMEOUT;
        cfg_wdata <= gap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        first_cfg = first;
        gap_cfg   = gap;
        phase_count++;
        quiet = ($urandom_range(3) == 0);
    endtask

    // Random mix: mostly well-formed frames, then corrupted frames,
    // transmit runs and loose words of any opcode
    task automatic run_mix(input int words);
        int stop_at;
        int roll;
        int pick;
        int n;
        stop_at = items_sent + words;
        while (items_sent < stop_at)
        begin
            roll = $urandom_range(99);
            pick = $urandom_range(99);
            if (roll < 45)
            begin
                if (pick < 70)
                    n = $urandom_range(10, 4);
                else if (pick < 82)
                    n = $urandom_range(3, 0);
                else if (pick < 95)
                    n = $urandom_range(31, 26);
                else
                    n = $urandom_range(33, 32);
                send_rx_frame(n, 1'b1);
            end
            else if (roll < 60)
                send_rx_frame($urandom_range(8), 1'b0);
            else if (roll < 85)
            begin
                if (pick < 70)
                    n = $urandom_range(6);
                else if (pick < 90)
                    n = $urandom_range(15, 7);
                else
                    n = $urandom_range(33, 26);
                send_tx(n);
            end
            else
            begin
                n = $urandom_range(3, 1);
                repeat (n) send_word(3'($urandom_range(7)), rnd_byte());
            end
        end
    endtask

    // Receiver: stall at random, or take every word while quiet
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(99) < 25)
            begin
                hold_left = pick_gap();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles in which neither channel moves a word
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles, %0d result words outstanding",
                 $time, WATCHDOG_LIMIT, pending);
        $display("tb_modbus_rtu_frame_engine NOT OK");
        $finish;
    end

    initial
    begin
        int k;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FIRST_BYTE_TIMEOUT;
        cfg_wdata <= 8'd0;
        in_valid  <= 1'b0;
        opcode    <= OP_ARM;
        data_byte <= 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-tick timeouts make every ending cheap
        settle_and_configure(8'd1, 8'd1);
        quiet = 1'b0;
        // Arm with no byte: timeout
        send_word(OP_ARM, rnd_byte());
        send_ticks(1);
        // Single byte: frame error
        send_word(OP_ARM, rnd_byte());
        send_word(OP_RX_BYTE, 8'hFF);
        send_ticks(1);
        // Four bytes with a bad CRC
        send_word(OP_ARM, rnd_byte());
        send_word(OP_RX_BYTE, 8'h00);
        send_word(OP_RX_BYTE, 8'hFF);
        send_word(OP_RX_BYTE, 8'h00);
        send_word(OP_RX_BYTE, 8'hFF);
        send_ticks(1);
        // Shortest good frame: two payload bytes and the CRC
        send_rx_frame(4, 1'b1);
        // Transmit of both byte extremes
        send_word(OP_TX_BYTE, 8'h00);
        send_word(OP_TX_BYTE, 8'hFF);
        send_word(OP_TX_END, rnd_byte());
        // Undecoded opcodes, and receive words while disarmed
        for (k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
            send_word(3'(k), rnd_byte());
        send_ticks(1);
        send_word(OP_RX_BYTE, rnd_byte());

        // Zero timeouts: the first tick ends every frame
        settle_and_configure(8'd0, 8'd0);
        run_mix(40);

        // Longest timeouts: end frames by overrun or by re-arming instead
        settle_and_configure(8'hFF, 8'hFF);
        send_word(OP_ARM, rnd_byte());
        send_ticks(2);
        repeat (3) send_word(OP_RX_BYTE, rnd_byte());
        // Transmit words while armed are dropped
        send_word(OP_TX_BYTE, rnd_byte());
        send_word(OP_TX_END, rnd_byte());
        send_ticks(2);
        send_rx_frame(BUFFER_BYTES_TB + 1, 1'b0);
        // Largest transmit that fits, then one past a full store
        send_tx(BUFFER_BYTES_TB - CRC_BYTES - 1);
        send_tx(BUFFER_BYTES_TB + 1);

        // Reset values: a frame that runs the full gap down
        settle_and_configure(FIRST_BYTE_TIMEOUT_RST, CHAR_GAP_TIMEOUT_RST);
        // Buffered transmit bytes are discarded by the arm
        repeat (3) send_word(OP_TX_BYTE, rnd_byte());
        send_rx_frame(6, 1'b1);
        send_tx(4);

        // Random phases with short timeouts until the word budget is spent
        k = 0;
        while (items_sent < ITEM_TARGET || k < 1)
        begin
            settle_and_configure(8'($urandom_range(4, 1)), 8'($urandom_range(4, 1)));
            run_mix(40);
            k++;
        end

        drain();
        $display("Covered %0d command words across %0d timeout settings, zero and 255 among them;",
                 items_sent, phase_count);
        $display("%0d result words checked over receive endings, overrun and transmit framing.",
                 checked_count);
        if (fail_count == 0)
            $display("tb_modbus_rtu_frame_engine OK");
        else
            $display("tb_modbus_rtu_frame_engine NOT OK");
        $finish;
    end

endmodule

/* modbus_rtu_frame_engine.f */
hdl/mbfe_pkg.sv
hdl/mbfe_crc16.sv
hdl/mbfe_frame_ram.sv
hdl/modbus_rtu_frame_engine.sv
test/modbus_rtu_frame_checker.sv
test/tb_modbus_rtu_frame_engine.sv
